// ===== design/assert_macros.svh =====
// Assertion macros shared by the matcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");

`else

`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== design/nobm_pkg.sv =====
// Types and constants of the nth-occurrence byte matcher.
package nobm_pkg;

	localparam int BYTE_W      = 8;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 2;
	localparam int LEN_W       = 5;
	localparam int COUNT_W     = 8;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PATTERN_LOW  = 2'd0,
		REG_PATTERN_HIGH = 2'd1,
		REG_PATTERN_LEN  = 2'd2,
		REG_OCC_WANTED   = 2'd3
	} cfg_reg_t;

	// Per-cycle control broadcast to every window cell.
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

endpackage

// ===== design/nobm_byte_if.sv =====
// Input byte stream channel.
interface nobm_byte_if;
	import nobm_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== design/nobm_result_if.sv =====
// Match result channel.
interface nobm_result_if #(
	parameter int POSITION_WIDTH = 16
);
	logic                      valid;
	logic                      ready;
	logic                      found;
	logic [POSITION_WIDTH-1:0] match_position;

	modport source (output valid, output found, output match_position, input ready);
	modport sink (input valid, input found, input match_position, output ready);
endinterface

// ===== design/nobm_cfg_if.sv =====
// Configuration register write channel.
interface nobm_cfg_if;
	import nobm_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] reg_index;
	logic [CFG_DATA_W-1:0]  wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== design/nobm_cell.sv =====
// One window cell: holds a byte, compares the incoming byte, extends the match chain.
module nobm_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  nobm_pkg::cell_ctl_t         ctl,
	input  logic [nobm_pkg::BYTE_W-1:0] shift_in,
	input  logic [nobm_pkg::BYTE_W-1:0] pat_byte,
	input  logic                        active,
	input  logic                        match_in,
	output logic [nobm_pkg::BYTE_W-1:0] held_byte,
	output logic                        match_out
);
	import nobm_pkg::*;

	logic [BYTE_W-1:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctl.clear) begin
			byte_q <= '0;
		end else if (ctl.shift) begin
			byte_q <= shift_in;
		end
	end

	// The byte entering this cell this cycle is the one compared.
	assign match_out = match_in & (~active | (shift_in == pat_byte));
	assign held_byte = byte_q;
endmodule

// ===== design/nth_occurrence_byte_matcher.sv =====
// Top level of the nth-occurrence byte matcher: config, window cell row, counters, result register.
//
//  channel   dir  payload                         handshake
//  byte_in   in   data_byte[7:0], last_byte       valid/ready
//  result    out  found, match_position[PW-1:0]   valid/ready
//  cfg       in   reg_index[1:0], wdata[63:0]     valid/ready, ready tied high
//
// One byte per cycle while byte_in.ready is high: the window shift and the compare across all
// cells complete in the accepting cycle, and a result lands in the output register on the next edge.
// byte_in.ready drops only while a held result is not taken; byte_in and result stall
// independently otherwise. Reset clears window, counters and config to defaults at once.
`include "assert_macros.svh"

module nth_occurrence_byte_matcher #(
	parameter int PATTERN_MAX    = 16,
	parameter int POSITION_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	nobm_byte_if.sink            byte_in,
	nobm_result_if.source        result,
	nobm_cfg_if.sink             cfg
);
	import nobm_pkg::*;

	localparam int PW     = POSITION_WIDTH;
	localparam int PIDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

	// configuration
	logic [BYTE_W-1:0]  pattern_q [PATTERN_MAX];
	logic [LEN_W-1:0]   pat_len_q;
	logic [COUNT_W-1:0] wanted_q;

	// search state
	logic [PW-1:0]      idx_q;
	logic [COUNT_W-1:0] cnt_q;
	logic               done_q;

	// result register
	logic               res_valid_q;
	logic               found_q;
	logic [PW-1:0]      pos_q;

	logic               cfg_fire;
	logic               in_fire;
	cell_ctl_t          ctl;
	logic [LEN_W-1:0]   len_act;
	logic [COUNT_W-1:0] wanted_act;
	logic [BYTE_W-1:0]  held [PATTERN_MAX];
	logic [BYTE_W-1:0]  pat_sel [PATTERN_MAX];
	logic               cell_act [PATTERN_MAX];
	logic               chain [PATTERN_MAX+1];
	logic [PW:0]        idx_next_ext;
	logic [PW:0]        len_ext;
	logic               enough;
	logic               hit;
	logic [COUNT_W-1:0] cnt_inc;
	logic               report;
	logic               emit;
	logic [PW-1:0]      pos_d;

	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid & cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_len_q <= LEN_W'(1);
			wanted_q  <= COUNT_W'(1);
		end else if (cfg_fire) begin
			unique case (cfg_reg_t'(cfg.reg_index))
				REG_PATTERN_LEN: pat_len_q <= cfg.wdata[LEN_W-1:0];
				REG_OCC_WANTED:  wanted_q  <= cfg.wdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_pat
		localparam cfg_reg_t PREG = (k < 8) ? REG_PATTERN_LOW : REG_PATTERN_HIGH;
		localparam int       LSB  = BYTE_W * (k % 8);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pattern_q[k] <= '0;
			end else if (cfg_fire && cfg_reg_t'(cfg.reg_index) == PREG) begin
				pattern_q[k] <= cfg.wdata[LSB +: BYTE_W];
			end
		end
	end

	// length 0 acts as 1, above the cell count it saturates
	always_comb begin
		if (pat_len_q == '0) begin
			len_act = LEN_W'(1);
		end else if (pat_len_q > LEN_W'(PATTERN_MAX)) begin
			len_act = LEN_W'(PATTERN_MAX);
		end else begin
			len_act = pat_len_q;
		end
	end

	assign wanted_act = (wanted_q == '0) ? COUNT_W'(1) : wanted_q;

	assign byte_in.ready = ~res_valid_q | result.ready;
	assign in_fire       = byte_in.valid & byte_in.ready;

	assign ctl.shift = in_fire & ~done_q & (idx_q != {PW{1'b1}});
	assign ctl.clear = in_fire & byte_in.last_byte;

	// cell k holds window entry k; it compares against pattern byte len-1-k
	assign chain[0] = 1'b1;
	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
		logic [LEN_W-1:0] pidx;

		assign pidx        = len_act - LEN_W'(1) - LEN_W'(k);
		assign cell_act[k] = LEN_W'(k) < len_act;
		assign pat_sel[k]  = pattern_q[pidx[PIDX_W-1:0]];

		nobm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.shift_in  ((k == 0) ? byte_in.data_byte : held[(k == 0) ? 0 : k-1]),
			.pat_byte  (pat_sel[k]),
			.active    (cell_act[k]),
			.match_in  (chain[k]),
			.held_byte (held[k]),
			.match_out (chain[k+1])
		);
	end

	// only matches wholly inside the buffer count
	assign idx_next_ext = {1'b0, idx_q} + (PW+1)'(1);
	assign len_ext      = (PW+1)'(len_act);
	assign enough       = idx_next_ext >= len_ext;
	assign hit          = ctl.shift & enough & chain[PATTERN_MAX];
	assign cnt_inc      = (cnt_q == {COUNT_W{1'b1}}) ? cnt_q : cnt_q + COUNT_W'(1);
	assign report       = hit & (cnt_inc >= wanted_act);
	assign emit         = report | (ctl.clear & ~done_q);
	assign pos_d        = report ? PW'(idx_next_ext - len_ext) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (ctl.clear) begin
			idx_q  <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (ctl.shift) begin
			idx_q <= idx_q + PW'(1);
			if (hit) begin
				cnt_q <= cnt_inc;
			end
			if (report) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (in_fire && emit) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && emit) begin
			found_q <= report;
			pos_q   <= pos_d;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.found          = found_q;
	assign result.match_position = pos_q;

	`ASSERT_AT(a_notfound_pos_zero, clk, arst_n, (res_valid_q && !found_q) |-> (pos_q == '0))
	`ASSERT_AT(a_last_restarts, clk, arst_n, (in_fire && byte_in.last_byte) |=> (idx_q == '0 && cnt_q == '0 && !done_q))
	`ASSERT_AT(a_done_has_count, clk, arst_n, done_q |-> (cnt_q != '0))
	`ASSERT_NEVER(a_no_shift_when_done, clk, arst_n, ctl.shift && done_q)
	`ASSERT_AT(a_report_sets_done, clk, arst_n, (report && !byte_in.last_byte) |=> done_q)
endmodule
